/* design/gsk_pkg.sv */
package gsk_pkg;

	typedef enum logic [1:0] {
		MODE_INIT,
		MODE_UPD,
		MODE_READ
	} mode_t;

	// Control part of the wavefront token that walks along the cells.
	typedef struct packed {
		logic        valid;
		mode_t       mode;
		logic [7:0]  sym;
		logic        sat;
	} tok_t;

	localparam logic [2:0] GAP_ADDR = 3'd0;

endpackage

/* design/gsk_satmul.sv */
module gsk_satmul #(
	parameter int VB = 48,
	parameter int BW = 17,
	parameter int F  = 16
) (
	input  logic [VB-1:0] a,
	input  logic [BW-1:0] b,
	output logic [VB-1:0] y,
	output logic          sat
);

	logic [VB+BW-1:0] prod;
	logic [VB+BW-1:0] shifted;

	always_comb begin
		prod    = {{BW{1'b0}}, a} * {{VB{1'b0}}, b};
		shifted = prod >> F;
		sat     = |shifted[VB+BW-1:VB];
		y       = sat ? {VB{1'b1}} : shifted[VB-1:0];
	end

endmodule

/* design/gsk_cell.sv */
module gsk_cell #(
	parameter int IDX   = 1,
	parameter int LEN_W = 7,
	parameter int VB    = 48,
	parameter int F     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [LEN_W-1:0]  len,
	input  logic              load_en,
	input  logic [LEN_W-1:0]  load_idx,
	input  logic [7:0]        load_sym,
	input  logic [F:0]        gap,
	input  logic [F+1:0]      g2,
	input  gsk_pkg::tok_t     ctl_i,
	input  logic [VB-1:0]     diag_i,
	input  logic [VB-1:0]     k1_i,
	input  logic [VB-1:0]     g1_i,
	input  logic [VB-1:0]     kout_i,
	output gsk_pkg::tok_t     ctl_o,
	output logic [VB-1:0]     diag_o,
	output logic [VB-1:0]     k1_o,
	output logic [VB-1:0]     g1_o,
	output logic [VB-1:0]     kout_o
);

	localparam logic [LEN_W-1:0] IDX_L = IDX[LEN_W-1:0];
	localparam logic [VB-1:0]    ONE   = {{(VB-1){1'b0}}, 1'b1} << F;

	logic [7:0]    sym_q;
	logic [VB-1:0] k_q;
	logic [VB-1:0] g_q;

	logic          active;
	logic [VB-1:0] m1, t, m3;
	logic          m1_sat, t_sat, m3_sat;

	gsk_pkg::tok_t ctl_s1;
	logic [VB-1:0] m1_s1, t_s1, m3_s1, k1_s1, kout_s1;
	logic          match_s1;

	logic [VB:0]   k1_sum, g1_sum, k_sum, g_sum;
	logic [VB-1:0] k1n, g1n, knew, gnew;
	logic          upd_sat;

	assign active = (len >= IDX_L);

	gsk_satmul #(.VB(VB), .BW(F+1), .F(F)) u_mul_g1 (
		.a(g1_i), .b(gap), .y(m1), .sat(m1_sat)
	);
	gsk_satmul #(.VB(VB), .BW(F+2), .F(F)) u_mul_diag (
		.a(diag_i), .b(g2), .y(t), .sat(t_sat)
	);
	gsk_satmul #(.VB(VB), .BW(F+1), .F(F)) u_mul_g (
		.a(g_q), .b(gap), .y(m3), .sat(m3_sat)
	);

	// Second stage: the saturating additions of one column.
	always_comb begin
		k1_sum = {1'b0, k1_s1} + {1'b0, t_s1};
		g1_sum = {1'b0, m1_s1} + {1'b0, t_s1};
		k1n    = match_s1 ? (k1_sum[VB] ? {VB{1'b1}} : k1_sum[VB-1:0]) : k1_s1;
		g1n    = match_s1 ? (g1_sum[VB] ? {VB{1'b1}} : g1_sum[VB-1:0]) : m1_s1;
		k_sum  = {1'b0, k_q} + {1'b0, k1n};
		g_sum  = {1'b0, m3_s1} + {1'b0, g1n};
		knew   = k_sum[VB] ? {VB{1'b1}} : k_sum[VB-1:0];
		gnew   = g_sum[VB] ? {VB{1'b1}} : g_sum[VB-1:0];
		upd_sat = (match_s1 & (k1_sum[VB] | g1_sum[VB])) | k_sum[VB] | g_sum[VB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.valid <= 1'b0;
			ctl_o.valid  <= 1'b0;
		end else begin
			ctl_s1.valid <= 1'b0;
			ctl_o.valid  <= 1'b0;
			if (ctl_i.valid && active) begin
				ctl_s1   <= ctl_i;
				m1_s1    <= m1;
				t_s1     <= t;
				m3_s1    <= m3;
				k1_s1    <= k1_i;
				kout_s1  <= kout_i;
				match_s1 <= (ctl_i.mode == gsk_pkg::MODE_UPD) && (sym_q == ctl_i.sym);
				case (ctl_i.mode)
					gsk_pkg::MODE_INIT: ctl_s1.sat <= ctl_i.sat | m1_sat;
					gsk_pkg::MODE_UPD:  ctl_s1.sat <= ctl_i.sat | m1_sat | m3_sat |
						((sym_q == ctl_i.sym) & t_sat);
					default:            ctl_s1.sat <= ctl_i.sat;
				endcase
			end else if (ctl_i.valid) begin
				// Columns beyond the second string only pass the token on.
				ctl_o  <= ctl_i;
				diag_o <= diag_i;
				k1_o   <= k1_i;
				g1_o   <= g1_i;
				kout_o <= kout_i;
			end
			if (ctl_s1.valid) begin
				ctl_o <= ctl_s1;
				case (ctl_s1.mode)
					gsk_pkg::MODE_INIT: begin
						k_q    <= ONE;
						g_q    <= m1_s1;
						g1_o   <= m1_s1;
						kout_o <= kout_s1;
					end
					gsk_pkg::MODE_UPD: begin
						k_q        <= knew;
						g_q        <= gnew;
						diag_o     <= g_q;
						k1_o       <= k1n;
						g1_o       <= g1n;
						kout_o     <= knew;
						ctl_o.sat  <= ctl_s1.sat | upd_sat;
					end
					default: begin
						kout_o <= k_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && load_idx == IDX_L) begin
			sym_q <= load_sym;
		end
	end

endmodule

/* design/gapped_subsequence_kernel_top.sv */
// A first-string symbol runs one wavefront along all MAX_LEN cells; a cell that holds a
// second-string symbol registers it in its first stage and then its outputs, the rest only in
// their outputs. The last second-string symbol (or an empty string) starts the same pass to set
// up the row; others are only loaded. Throughput is one item per pass, set by the cell chain.
// Results come as a one-cycle done strobe and cannot be stalled.
// Reset clears the control state and sets the gap to one half; cell contents are loaded later.
module gapped_subsequence_kernel_top #(
	parameter int MAX_LEN       = 64,
	parameter int VALUE_BITS    = 48,
	parameter int GAP_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [7:0]            symbol,
	input  logic                  string_select,
	input  logic                  empty_string,
	input  logic                  last_symbol,
	output logic                  done,
	output logic [VALUE_BITS-1:0] kernel_value,
	output logic                  saturated,
	output logic                  too_long,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int VB    = VALUE_BITS;
	localparam int F     = GAP_FRAC_BITS;
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam logic [VB-1:0]    ONE     = {{(VB-1){1'b0}}, 1'b1} << F;
	localparam logic [F:0]       GAP_RST = {{F{1'b0}}, 1'b1} << (F - 1);
	localparam logic [LEN_W-1:0] LEN_MAX = MAX_LEN[LEN_W-1:0];

	logic [F:0]       gap_q;
	logic [F+1:0]     g2_q;
	logic [2*F+1:0]   gap_sq;
	logic             phase_q;
	logic [LEN_W-1:0] len_q;
	logic             sticky_sat_q;
	logic             too_long_q;
	logic             busy_q;
	logic             result_q;
	logic [VB-1:0]    g0_q;
	logic [VB-1:0]    g0_mul;
	logic             g0_sat;
	logic             accept;
	logic             cfg_wr;
	logic             load_en;
	logic [LEN_W-1:0] load_idx;

	gsk_pkg::tok_t ctl_c  [MAX_LEN+1];
	logic [VB-1:0] diag_c [MAX_LEN+1];
	logic [VB-1:0] k1_c   [MAX_LEN+1];
	logic [VB-1:0] g1_c   [MAX_LEN+1];
	logic [VB-1:0] kout_c [MAX_LEN+1];

	gsk_pkg::tok_t iss_ctl_q;
	logic [VB-1:0] iss_diag_q;
	logic [VB-1:0] iss_g1_q;
	logic          exit_tok;

	assign pready   = 1'b1;
	assign busy     = busy_q;
	assign accept   = start & ~busy_q;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign prdata   = (paddr == gsk_pkg::GAP_ADDR) ? {{(31-F){1'b0}}, gap_q} : 32'd0;
	assign gap_sq   = {{(F+1){1'b0}}, gap_q} * {{(F+1){1'b0}}, gap_q};
	assign load_en  = accept & ~phase_q & ~string_select & ~empty_string & (len_q < LEN_MAX);
	assign load_idx = len_q + {{(LEN_W-1){1'b0}}, 1'b1};
	assign exit_tok = ctl_c[MAX_LEN].valid;

	assign ctl_c[0]  = iss_ctl_q;
	assign diag_c[0] = iss_diag_q;
	assign k1_c[0]   = '0;
	assign g1_c[0]   = iss_g1_q;
	assign kout_c[0] = ONE;

	gsk_satmul #(.VB(VB), .BW(F+1), .F(F)) u_col0 (
		.a(g0_q), .b(gap_q), .y(g0_mul), .sat(g0_sat)
	);

	for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
		gsk_cell #(.IDX(j), .LEN_W(LEN_W), .VB(VB), .F(F)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.len     (len_q),
			.load_en (load_en),
			.load_idx(load_idx),
			.load_sym(symbol),
			.gap     (gap_q),
			.g2      (g2_q),
			.ctl_i   (ctl_c[j-1]),
			.diag_i  (diag_c[j-1]),
			.k1_i    (k1_c[j-1]),
			.g1_i    (g1_c[j-1]),
			.kout_i  (kout_c[j-1]),
			.ctl_o   (ctl_c[j]),
			.diag_o  (diag_c[j]),
			.k1_o    (k1_c[j]),
			.g1_o    (g1_c[j]),
			.kout_o  (kout_c[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q           <= GAP_RST;
			phase_q         <= 1'b0;
			len_q           <= '0;
			sticky_sat_q    <= 1'b0;
			too_long_q      <= 1'b0;
			busy_q          <= 1'b0;
			result_q        <= 1'b0;
			iss_ctl_q.valid <= 1'b0;
			done            <= 1'b0;
		end else begin
			iss_ctl_q.valid <= 1'b0;
			done            <= 1'b0;
			if (cfg_wr && paddr == gsk_pkg::GAP_ADDR) begin
				gap_q <= pwdata[F:0];
			end
			if (accept && !phase_q && !string_select) begin
				if (!empty_string) begin
					if (len_q < LEN_MAX) begin
						len_q <= load_idx;
					end else begin
						too_long_q <= 1'b1;
					end
				end
				if (empty_string || last_symbol) begin
					phase_q        <= 1'b1;
					busy_q         <= 1'b1;
					result_q       <= 1'b0;
					g0_q           <= ONE;
					iss_ctl_q      <= '{valid: 1'b1, mode: gsk_pkg::MODE_INIT,
						sym: symbol, sat: 1'b0};
					iss_g1_q       <= ONE;
				end
			end else if (accept && phase_q && string_select) begin
				busy_q   <= 1'b1;
				result_q <= empty_string | last_symbol;
				if (empty_string) begin
					iss_ctl_q <= '{valid: 1'b1, mode: gsk_pkg::MODE_READ,
						sym: symbol, sat: 1'b0};
				end else begin
					iss_ctl_q  <= '{valid: 1'b1, mode: gsk_pkg::MODE_UPD,
						sym: symbol, sat: g0_sat};
					iss_diag_q <= g0_q;
					iss_g1_q   <= '0;
					g0_q       <= g0_mul;
				end
			end
			if (exit_tok) begin
				busy_q <= 1'b0;
				if (result_q) begin
					done         <= 1'b1;
					kernel_value <= kout_c[MAX_LEN];
					saturated    <= sticky_sat_q | ctl_c[MAX_LEN].sat;
					too_long     <= too_long_q;
					phase_q      <= 1'b0;
					len_q        <= '0;
					sticky_sat_q <= 1'b0;
					too_long_q   <= 1'b0;
				end else begin
					sticky_sat_q <= sticky_sat_q | ctl_c[MAX_LEN].sat;
				end
			end
		end
	end

	// The square of the gap is registered from the gap register and follows it in the next cycle.
	always_ff @(posedge clk) begin
		g2_q <= gap_sq[2*F+1:F];
	end

`ifndef SYNTH
	a_done_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("result given without a pass in flight");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("second string length beyond the cell count");
	a_token_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_tok |-> busy_q)
		else $error("token left the chain while idle");
	a_no_issue_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		iss_ctl_q.valid |-> !$past(busy_q))
		else $error("token issued while a pass was running");
`endif

endmodule
